/* hw/rtl/ukst_pkg.sv */
package ukst_pkg;

    // Fixed widths of the request and response fields.
    localparam int OP_W          = 2;
    localparam int KEY_FIELD_W   = 32;
    localparam int STATUS_W      = 2;
    localparam int COUNT_FIELD_W = 4;

    // Widest key the table is built for; used to zero-extend the key field.
    localparam int MAX_KEY_W     = 64;

    // Defaults for the top-level parameters.
    localparam int DEF_CAPACITY  = 10;
    localparam int DEF_KEY_WIDTH = 32;

    // Operation codes.
    localparam logic [OP_W-1:0] OP_ADD    = 2'd0;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
    localparam logic [OP_W-1:0] OP_QUERY  = 2'd2;

    // Status codes.
    localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_DUP  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;
    localparam logic [STATUS_W-1:0] ST_MISS = 2'd3;

    // Commit strobes broadcast to every cell of the chain.
    typedef struct packed {
        logic add_commit;
        logic remove_commit;
    } cell_ctrl_t;

endpackage

/* hw/rtl/ukst_if.sv */
interface ukst_req_if;
    logic                              valid;
    logic                              ready;
    logic [ukst_pkg::OP_W-1:0]         operation;
    logic [ukst_pkg::KEY_FIELD_W-1:0]  key;

    modport source (output valid, output operation, output key, input ready);
    modport sink   (input valid, input operation, input key, output ready);
endinterface

interface ukst_rsp_if;
    logic                               valid;
    logic                               ready;
    logic [ukst_pkg::STATUS_W-1:0]      status;
    logic                               found;
    logic [ukst_pkg::COUNT_FIELD_W-1:0] entry_count;

    modport source (output valid, output status, output found, output entry_count, input ready);
    modport sink   (input valid, input status, input found, input entry_count, output ready);
endinterface

/* hw/rtl/ukst_cell.sv */
module ukst_cell #(
    parameter int KEY_WIDTH = ukst_pkg::DEF_KEY_WIDTH,
    parameter int CNT_W     = 4,
    parameter int INDEX     = 0
) (
    input  logic                    clk,
    input  logic [KEY_WIDTH-1:0]    key,
    input  logic [KEY_WIDTH-1:0]    upper_entry,
    input  logic [CNT_W-1:0]        count,
    input  ukst_pkg::cell_ctrl_t    ctrl,
    input  logic                    chain_in,
    output logic                    chain_out,
    output logic                    match,
    output logic [KEY_WIDTH-1:0]    entry
);

    logic [KEY_WIDTH-1:0] entry_reg;
    logic [KEY_WIDTH-1:0] entry_next;
    logic                 cell_valid;

    // A cell holds a live key when its position lies below the count.
    assign cell_valid = count > CNT_W'(INDEX);
    assign match      = cell_valid && (entry_reg == key);

    // The chain carries "a match sits at or below this cell" upward.
    assign chain_out  = chain_in | match;
    assign entry      = entry_reg;

    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.add_commit && (count == CNT_W'(INDEX)))
        begin
            entry_next = key;
        end
        else if (ctrl.remove_commit && chain_out)
        begin
            // Close the gap by taking the neighbor's key.
            entry_next = upper_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

/* hw/rtl/unique_key_set_table_core.sv */
// Ordered set of up to CAPACITY distinct keys, KEY_WIDTH bits each.
// The req channel carries one request (operation and key); the rsp channel
// returns exactly one response per request with a status, a found flag and
// the number of stored keys after the request.
// Add appends a key when it is not already present and the table has room.
// Remove deletes the matching key and moves every later key down one place.
// Query, and the unused fourth operation code, only report presence.
// The cells compare the key in parallel and update when the request is
// accepted, and the response is registered, so it appears on rsp in the
// cycle after the request is accepted. A new request can be accepted every
// cycle as long as the receiver takes each response.
// When the receiver stalls, the response register holds its contents and
// req.ready stays low until that response is taken.
// Reset empties the table (the count goes to zero) and drops any pending
// response; the stored keys themselves are not cleared.
module unique_key_set_table_core #(
    parameter int CAPACITY  = ukst_pkg::DEF_CAPACITY,
    parameter int KEY_WIDTH = ukst_pkg::DEF_KEY_WIDTH
) (
    input  logic          clk,
    input  logic          rst_n,
    ukst_req_if.sink      req,
    ukst_rsp_if.source    rsp
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic [CNT_W-1:0]                   count_reg;
    logic [CNT_W-1:0]                   count_next;
    logic                               rsp_valid_reg;
    logic [ukst_pkg::STATUS_W-1:0]      status_reg;
    logic                               found_reg;
    logic [ukst_pkg::COUNT_FIELD_W-1:0] entry_count_reg;

    logic                               fire;
    logic [ukst_pkg::MAX_KEY_W-1:0]     key_wide;
    logic [KEY_WIDTH-1:0]               key_k;
    logic                               hit;
    logic                               full;
    logic [ukst_pkg::STATUS_W-1:0]      status_next;
    logic [CNT_W+ukst_pkg::COUNT_FIELD_W-1:0] count_ext;
    ukst_pkg::cell_ctrl_t               ctrl;

    logic                               chain [CAPACITY+1];
    logic [KEY_WIDTH-1:0]               entry_q [CAPACITY+1];
    logic [CAPACITY-1:0]                match_vec;

    // A new request is taken whenever the response register is free or is
    // being emptied in the same cycle.
    assign req.ready = !rsp_valid_reg || rsp.ready;
    assign fire      = req.valid && req.ready;

    // Key bits above KEY_WIDTH are ignored; narrow keys are zero-extended.
    assign key_wide  = {{(ukst_pkg::MAX_KEY_W - ukst_pkg::KEY_FIELD_W){1'b0}}, req.key};
    assign key_k     = key_wide[KEY_WIDTH-1:0];

    // The chain starts empty below cell zero; the top cell pulls in zeros.
    assign chain[0]          = 1'b0;
    assign entry_q[CAPACITY] = '0;

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        ukst_cell #(
            .KEY_WIDTH (KEY_WIDTH),
            .CNT_W     (CNT_W),
            .INDEX     (i)
        ) u_cell (
            .clk         (clk),
            .key         (key_k),
            .upper_entry (entry_q[i+1]),
            .count       (count_reg),
            .ctrl        (ctrl),
            .chain_in    (chain[i]),
            .chain_out   (chain[i+1]),
            .match       (match_vec[i]),
            .entry       (entry_q[i])
        );
    end

    assign hit  = chain[CAPACITY];
    assign full = count_reg == CNT_W'(CAPACITY);

    // Duplicate check comes before the full check on an add.
    always_comb
    begin
        status_next        = ukst_pkg::ST_OK;
        count_next         = count_reg;
        ctrl.add_commit    = 1'b0;
        ctrl.remove_commit = 1'b0;
        unique case (req.operation)
            ukst_pkg::OP_ADD:
            begin
                if (hit)
                begin
                    status_next = ukst_pkg::ST_DUP;
                end
                else if (full)
                begin
                    status_next = ukst_pkg::ST_FULL;
                end
                else
                begin
                    ctrl.add_commit = fire;
                    count_next      = count_reg + CNT_W'(1);
                end
            end
            ukst_pkg::OP_REMOVE:
            begin
                if (hit)
                begin
                    ctrl.remove_commit = fire;
                    count_next         = count_reg - CNT_W'(1);
                end
                else
                begin
                    status_next = ukst_pkg::ST_MISS;
                end
            end
            default:
            begin
                status_next = ukst_pkg::ST_OK;
            end
        endcase
    end

    assign count_ext = {{ukst_pkg::COUNT_FIELD_W{1'b0}}, count_next};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (fire)
            begin
                count_reg     <= count_next;
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            status_reg      <= status_next;
            found_reg       <= hit;
            entry_count_reg <= count_ext[ukst_pkg::COUNT_FIELD_W-1:0];
        end
    end

    assign rsp.valid       = rsp_valid_reg;
    assign rsp.status      = status_reg;
    assign rsp.found       = found_reg;
    assign rsp.entry_count = entry_count_reg;

    // The count never runs past the number of cells.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count exceeds capacity");

    // Stored keys are distinct, so at most one live cell can match.
    a_unique_match: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(match_vec))
        else $error("more than one cell matches the key");

    // A successful add grows the table by exactly one key.
    a_add_grows: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.add_commit |=> count_reg == $past(count_reg) + CNT_W'(1))
        else $error("add did not grow the count by one");

    // A successful remove shrinks the table by exactly one key.
    a_remove_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.remove_commit |=> count_reg == $past(count_reg) - CNT_W'(1))
        else $error("remove did not shrink the count by one");

    // Found flag agrees with the status of a rejected request.
    a_status_found: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg |->
            ((status_reg == ukst_pkg::ST_DUP) == found_reg) ||
            (status_reg == ukst_pkg::ST_OK))
        else $error("status and found flag disagree");

endmodule
